/* sv/ffa_pkg.sv */
`default_nettype none
package ffa_pkg;

	localparam int SIZE_W = 20;

	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_RELEASE = 2'd2,
		OP_NOP     = 2'd3
	} opcode_t;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OOM = 1'b1;

	localparam logic REG_HEAP_BYTES = 1'b0;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_A_RD   = 10'b0000000010,
		ST_A_CHK  = 10'b0000000100,
		ST_A_FIX  = 10'b0000001000,
		ST_R_TEST = 10'b0000010000,
		ST_R_NEXT = 10'b0000100000,
		ST_R_PREV = 10'b0001000000,
		ST_M_RD   = 10'b0010000000,
		ST_M_CHK  = 10'b0100000000,
		ST_M_WR   = 10'b1000000000
	} state_t;

	typedef enum logic {
		PH_FIRST = 1'b0,
		PH_LAST  = 1'b1
	} phase_t;

endpackage
`default_nettype wire

/* sv/first_fit_heap_allocator_unit.sv */
// Init, the unused opcode and a release below the header size or past the header memory
// finish in the cycle after the transfer. Allocate reads and checks each free block in turn,
// then fixes the list; the registered header memory read sets this pace. Release walks the
// free blocks below the target, links the block in and merges it with its neighbors.
// One item is worked at a time; busy is high until its result strobe, which cannot be stalled.
// Reset empties the free list and sets heap_bytes to 32768; header memories hold no reset value.
`default_nettype none
module first_fit_heap_allocator_unit import ffa_pkg::*; #(
	parameter int HEAP_BYTES   = 32768,
	parameter int HEADER_BYTES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [15:0] request_bytes,
	input  wire logic [14:0] block_offset,
	output logic             done,
	output logic             status,
	output logic [14:0]      payload_offset,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int DEPTH = HEAP_BYTES / 8;
	localparam int AW    = $clog2(DEPTH);
	localparam int OW    = $clog2(HEAP_BYTES);
	localparam int CW    = OW + 3 > 22 ? OW + 3 : 22;
	localparam int STW   = $clog2(DEPTH + 2);
	localparam int CAP   = (HEAP_BYTES / 8) * 8;

	typedef struct packed {
		logic          nul;
		logic [OW-1:0] off;
	} link_t;

	localparam link_t NULL_LINK = '{nul: 1'b1, off: '0};

	state_t          state_q;
	phase_t          phase_q;
	link_t           head_q, cur_q, prev_q, nx_q, blk_q;
	logic [OW-1:0]   hdr_q;
	logic [14:0]     ptr_q;
	logic [16:0]     sz_q;
	logic [SIZE_W-1:0] s_q;
	logic [STW-1:0]  steps_q;
	logic            split_q, oor_q;
	logic [15:0]     heap_q;

	logic              sz_we, ln_we;
	logic [AW-1:0]     sz_addr, ln_addr;
	logic [SIZE_W-1:0] sz_wd, sz_rd, rsize;
	link_t             ln_wd, ln_rd, rlink;

	logic [CW-1:0] e_c, hdr_c, nb_c;
	logic          hit, split, do_walk, do_merge, cfg_wr;

	function automatic logic in_store(input logic [OW-1:0] o);
		in_store = (CW'(o) >> 3) < CW'(DEPTH);
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [OW-1:0] o);
		addr_of = o[AW+2:3];
	endfunction

	ffa_ram #(.WIDTH(SIZE_W), .DEPTH(DEPTH)) u_size_ram (
		.clk(clk), .we(sz_we), .addr(sz_addr), .wdata(sz_wd), .rdata(sz_rd)
	);

	ffa_ram #(.WIDTH(OW + 1), .DEPTH(DEPTH)) u_link_ram (
		.clk(clk), .we(ln_we), .addr(ln_addr), .wdata(ln_wd), .rdata(ln_rd)
	);

	assign rsize = oor_q ? '0 : sz_rd;
	assign rlink = oor_q ? NULL_LINK : ln_rd;

	assign e_c = (CW'({heap_q[15:3], 3'b000}) > CW'(CAP)) ? CW'(CAP)
		: CW'({heap_q[15:3], 3'b000});
	assign hdr_c = CW'(block_offset) - CW'(HEADER_BYTES);
	assign nb_c = CW'(cur_q.off) + CW'(HEADER_BYTES) + CW'(sz_q);
	assign hit = CW'(rsize) >= CW'(sz_q);
	assign split = CW'(rsize) > CW'(sz_q) + CW'(HEADER_BYTES);
	assign do_walk = !cur_q.nul && (CW'(cur_q.off) < CW'(ptr_q));
	assign do_merge = !rlink.nul
		&& (CW'(blk_q.off) + CW'(HEADER_BYTES) + CW'(rsize) == CW'(rlink.off));

	assign busy = (state_q != ST_IDLE);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_HEAP_BYTES) ? {16'd0, heap_q} : 32'd0;

	always_comb begin
		sz_we = 1'b0;
		ln_we = 1'b0;
		sz_addr = '0;
		ln_addr = '0;
		sz_wd = '0;
		ln_wd = NULL_LINK;
		unique case (state_q)
			ST_IDLE: begin
				if (start && opcode == OP_INIT && e_c >= CW'(HEADER_BYTES)) begin
					sz_we = 1'b1;
					ln_we = 1'b1;
					sz_wd = SIZE_W'(e_c - CW'(HEADER_BYTES));
				end
			end
			ST_A_RD: begin
				sz_addr = addr_of(cur_q.off);
				ln_addr = addr_of(cur_q.off);
			end
			ST_A_CHK: begin
				sz_addr = addr_of(OW'(nb_c));
				ln_addr = addr_of(OW'(nb_c));
				sz_wd = SIZE_W'(CW'(rsize) - CW'(sz_q) - CW'(HEADER_BYTES));
				ln_wd = rlink;
				if (hit && split && in_store(OW'(nb_c))) begin
					sz_we = 1'b1;
					ln_we = 1'b1;
				end
			end
			ST_A_FIX: begin
				sz_addr = addr_of(cur_q.off);
				sz_wd = SIZE_W'(sz_q);
				sz_we = split_q && in_store(cur_q.off);
				ln_addr = addr_of(prev_q.off);
				ln_wd = nx_q;
				ln_we = !prev_q.nul && in_store(prev_q.off);
			end
			ST_R_TEST: begin
				if (do_walk) begin
					ln_addr = addr_of(cur_q.off);
				end else begin
					ln_addr = addr_of(hdr_q);
					ln_wd = cur_q;
					ln_we = (cur_q != link_t'{nul: 1'b0, off: hdr_q});
				end
			end
			ST_R_NEXT: begin
				ln_addr = addr_of(cur_q.off);
			end
			ST_R_PREV: begin
				ln_addr = addr_of(prev_q.off);
				ln_wd = '{nul: 1'b0, off: hdr_q};
				ln_we = !prev_q.nul;
			end
			ST_M_RD: begin
				sz_addr = addr_of(blk_q.off);
				ln_addr = addr_of(blk_q.off);
			end
			ST_M_CHK: begin
				sz_addr = addr_of(rlink.off);
				ln_addr = addr_of(rlink.off);
			end
			ST_M_WR: begin
				sz_addr = addr_of(blk_q.off);
				ln_addr = addr_of(blk_q.off);
				sz_wd = SIZE_W'(s_q + rsize + SIZE_W'(HEADER_BYTES));
				ln_wd = rlink;
				sz_we = 1'b1;
				ln_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= NULL_LINK;
			heap_q <= 16'd32768;
			done <= 1'b0;
			status <= STATUS_OK;
			payload_offset <= '0;
			phase_q <= PH_FIRST;
			oor_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_wr && paddr[2] == REG_HEAP_BYTES) begin
				heap_q <= pwdata[15:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						status <= STATUS_OK;
						payload_offset <= '0;
						cur_q <= head_q;
						prev_q <= NULL_LINK;
						steps_q <= '0;
						case (opcode)
							OP_INIT: begin
								done <= 1'b1;
								head_q <= (e_c >= CW'(HEADER_BYTES))
									? link_t'{nul: 1'b0, off: '0} : NULL_LINK;
							end
							OP_ALLOC: begin
								sz_q <= (17'(request_bytes) + 17'd7) & ~17'd7;
								state_q <= ST_A_RD;
							end
							OP_RELEASE: begin
								ptr_q <= block_offset;
								hdr_q <= OW'(hdr_c);
								if (CW'(block_offset) < CW'(HEADER_BYTES)
									|| (hdr_c >> 3) >= CW'(DEPTH)) begin
									done <= 1'b1;
								end else begin
									state_q <= ST_R_TEST;
								end
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				ST_A_RD: begin
					if (cur_q.nul || steps_q > STW'(DEPTH)) begin
						done <= 1'b1;
						status <= STATUS_OOM;
						state_q <= ST_IDLE;
					end else begin
						oor_q <= !in_store(cur_q.off);
						state_q <= ST_A_CHK;
					end
				end
				ST_A_CHK: begin
					if (hit) begin
						split_q <= split;
						nx_q <= split ? link_t'{nul: 1'b0, off: OW'(nb_c)} : rlink;
						state_q <= ST_A_FIX;
					end else begin
						prev_q <= cur_q;
						cur_q <= rlink;
						steps_q <= steps_q + 1'b1;
						state_q <= ST_A_RD;
					end
				end
				ST_A_FIX: begin
					if (prev_q.nul) begin
						head_q <= nx_q;
					end
					payload_offset <= 15'(CW'(cur_q.off) + CW'(HEADER_BYTES));
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_R_TEST: begin
					if (do_walk) begin
						if (cur_q.off == hdr_q || steps_q > STW'(DEPTH)) begin
							done <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							prev_q <= cur_q;
							oor_q <= !in_store(cur_q.off);
							state_q <= ST_R_NEXT;
						end
					end else if (cur_q == link_t'{nul: 1'b0, off: hdr_q}) begin
						done <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_R_PREV;
					end
				end
				ST_R_NEXT: begin
					cur_q <= rlink;
					steps_q <= steps_q + 1'b1;
					state_q <= ST_R_TEST;
				end
				ST_R_PREV: begin
					if (prev_q.nul) begin
						head_q <= '{nul: 1'b0, off: hdr_q};
						blk_q <= '{nul: 1'b0, off: hdr_q};
						phase_q <= PH_LAST;
					end else begin
						blk_q <= prev_q;
						phase_q <= PH_FIRST;
					end
					state_q <= ST_M_RD;
				end
				ST_M_RD: begin
					oor_q <= 1'b0;
					state_q <= ST_M_CHK;
				end
				ST_M_CHK: begin
					if (do_merge) begin
						s_q <= rsize;
						oor_q <= !in_store(rlink.off);
						state_q <= ST_M_WR;
					end else if (phase_q == PH_FIRST) begin
						blk_q <= '{nul: 1'b0, off: hdr_q};
						phase_q <= PH_LAST;
						state_q <= ST_M_RD;
					end else begin
						done <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_M_WR: begin
					if (phase_q == PH_FIRST) begin
						phase_q <= PH_LAST;
						state_q <= ST_M_RD;
					end else begin
						done <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* sv/ffa_ram.sv */
`default_nettype none
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

/* sv/ffa_checker.sv */
`default_nettype none
module ffa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        status,
	input wire logic [14:0] payload_offset
);

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("Accepted transfer neither finished nor kept the block busy.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result strobe while still busy.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> payload_offset == 15'd0)
		else $error("Failed allocate returned a nonzero offset.");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("Busy dropped without a result.");

endmodule

bind first_fit_heap_allocator_unit ffa_checker u_ffa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.payload_offset(payload_offset)
);
`default_nettype wire

/* tb/first_fit_heap_allocator_unit_tb.sv */
`default_nettype none
module first_fit_heap_allocator_unit_tb;
	import ffa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HEAP = 32768;
	localparam int unsigned HDR = 16;
	localparam int unsigned DEPTH = HEAP / 8;
	localparam int unsigned NIL = 32'hFFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] opcode = OP_NOP;
	logic [15:0] request_bytes = '0;
	logic [14:0] block_offset = '0;
	logic done;
	logic status;
	logic [14:0] payload_offset;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	first_fit_heap_allocator_unit #(.HEAP_BYTES(HEAP), .HEADER_BYTES(HDR)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.request_bytes(request_bytes), .block_offset(block_offset), .done(done),
		.status(status), .payload_offset(payload_offset), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		logic        status;
		logic [14:0] payload;
	} alloc_result_t;

	typedef struct {
		opcode_t     op;
		logic [15:0] req;
		logic [14:0] off;
		bit          typed;
		logic        st;
		logic [14:0] pay;
	} heap_cmd_t;

	alloc_result_t expected_results[$];
	int unsigned   live_blocks[$];
	int unsigned   freed_blocks[$];
	int            errors = 0;

	logic [19:0] size_mem [DEPTH];
	int unsigned link_mem [DEPTH];
	int unsigned free_head = NIL;
	int unsigned heap_reg = 32768;

	function automatic int unsigned hdr_size(int unsigned o);
		if (o == NIL || o / 8 >= DEPTH) return 0;
		return size_mem[o / 8];
	endfunction

	function automatic int unsigned hdr_link(int unsigned o);
		if (o == NIL || o / 8 >= DEPTH) return NIL;
		return link_mem[o / 8];
	endfunction

	function automatic void set_size(int unsigned o, int unsigned v);
		if (o != NIL && o / 8 < DEPTH) begin
			size_mem[o / 8] = v[19:0];
		end
	endfunction

	function automatic void set_link(int unsigned o, int unsigned v);
		if (o != NIL && o / 8 < DEPTH) link_mem[o / 8] = v;
	endfunction

	function automatic bit absorb_next(int unsigned blk);
		int unsigned s, n;
		s = hdr_size(blk);
		n = hdr_link(blk);
		if (n != NIL && blk + HDR + s == n) begin
			set_size(blk, s + hdr_size(n) + HDR);
			set_link(blk, hdr_link(n));
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic alloc_result_t heap_predict(opcode_t op, int unsigned req,
			int unsigned off);
		alloc_result_t r;
		int unsigned e, sz, prev, cur, steps, s, nx, nb, hdr;
		r = '0;
		prev = NIL;
		steps = 0;
		case (op)
			OP_INIT: begin
				e = heap_reg & ~32'd7;
				if (e > HEAP) e = HEAP;
				if (e < HDR) free_head = NIL;
				else begin
					set_link(0, NIL);
					set_size(0, e - HDR);
					free_head = 0;
				end
			end
			OP_ALLOC: begin
				sz = (req + 7) & ~32'd7;
				cur = free_head;
				r.status = STATUS_OOM;
				while (cur != NIL && steps <= DEPTH) begin
					s = hdr_size(cur);
					if (s >= sz) begin
						nx = hdr_link(cur);
						if (s > sz + HDR) begin
							nb = cur + HDR + sz;
							set_link(nb, nx);
							set_size(nb, s - sz - HDR);
							set_size(cur, sz);
							nx = nb;
						end
						if (prev == NIL) free_head = nx;
						else set_link(prev, nx);
						r.status = STATUS_OK;
						r.payload = 15'(cur + HDR);
						break;
					end
					prev = cur;
					cur = hdr_link(cur);
					steps++;
				end
			end
			OP_RELEASE: begin
				if (off >= HDR) begin
					hdr = off - HDR;
					cur = free_head;
					while (cur != NIL && cur < off) begin
						if (cur == hdr || steps > DEPTH) return r;
						prev = cur;
						cur = hdr_link(cur);
						steps++;
					end
					if (cur != hdr) begin
						set_link(hdr, cur);
						if (prev != NIL) begin
							set_link(prev, hdr);
							if (absorb_next(prev)) void'(absorb_next(prev));
							else void'(absorb_next(hdr));
						end else begin
							free_head = hdr;
							void'(absorb_next(hdr));
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (expected_results.size() == 0) begin
				$display("unexpected transfer at %0t", $realtime);
				errors++;
			end else begin
				alloc_result_t want;
				want = expected_results.pop_front();
				if (status !== want.status) report_mismatch("status", status, want.status);
				if (payload_offset !== want.payload)
					report_mismatch("payload_offset", payload_offset, want.payload);
			end
		end
	end

	task automatic send_cmd(heap_cmd_t c);
		alloc_result_t r;
		r = heap_predict(c.op, c.req, c.off);
		if (c.op == OP_ALLOC && r.status == STATUS_OK) live_blocks.push_back(r.payload);
		if (c.op == OP_INIT) live_blocks.delete();
		if (c.typed) begin
			r.status = c.st;
			r.payload = c.pay;
		end
		expected_results.push_back(r);
		start <= 1'b1;
		opcode <= c.op;
		request_bytes <= c.req;
		block_offset <= c.off;
		do @(posedge clk); while (busy);
	endtask

	task automatic sender_gap();
		int g;
		g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_heap_bytes(int unsigned v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(4 * REG_HEAP_BYTES);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[15:0] !== v[15:0]) report_mismatch("heap_bytes readback", prdata, v);
		psel <= 1'b0;
		penable <= 1'b0;
		heap_reg = v & 32'hFFFF;
	endtask

	task automatic random_cmd(output heap_cmd_t c);
		int unsigned pick, idx;
		c.typed = 1'b0;
		c.st = 1'b0;
		c.pay = '0;
		c.req = 16'($urandom);
		c.off = 15'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			c.op = OP_ALLOC;
			c.req = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 4096))
				: 16'($urandom_range(0, 256));
		end else if (pick < 85 && live_blocks.size() != 0) begin
			c.op = OP_RELEASE;
			idx = $urandom_range(0, live_blocks.size() - 1);
			c.off = 15'(live_blocks[idx]);
			live_blocks.delete(idx);
			freed_blocks.push_back(c.off);
			if (freed_blocks.size() > 64) void'(freed_blocks.pop_front());
		end else if (pick < 88 && freed_blocks.size() != 0) begin
			c.op = OP_RELEASE;
			c.off = 15'(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
		end else if (pick < 90) begin
			c.op = OP_RELEASE;
			c.off = 15'($urandom_range(0, HDR - 1));
		end else if (pick < 93) begin
			c.op = OP_NOP;
		end else if (pick < 96) begin
			c.op = OP_INIT;
		end else begin
			c.op = OP_ALLOC;
		end
	endtask

	heap_cmd_t directed [] = '{
		'{OP_ALLOC,   16'd16,    15'd0,     1'b1, STATUS_OOM, 15'd0},
		'{OP_RELEASE, 16'd0,     15'd0,     1'b1, STATUS_OK,  15'd0},
		'{OP_NOP,     16'hFFFF,  15'h7FFF,  1'b1, STATUS_OK,  15'd0},
		'{OP_INIT,    16'd0,     15'd0,     1'b1, STATUS_OK,  15'd0},
		'{OP_ALLOC,   16'd0,     15'd0,     1'b1, STATUS_OK,  15'd16},
		'{OP_ALLOC,   16'd1,     15'd0,     1'b1, STATUS_OK,  15'd32},
		'{OP_ALLOC,   16'hFFFF,  15'd0,     1'b1, STATUS_OOM, 15'd0},
		'{OP_ALLOC,   16'd32768, 15'd0,     1'b1, STATUS_OOM, 15'd0},
		'{OP_RELEASE, 16'd0,     15'd32,    1'b1, STATUS_OK,  15'd0},
		'{OP_RELEASE, 16'd0,     15'd32,    1'b1, STATUS_OK,  15'd0},
		'{OP_RELEASE, 16'd0,     15'd15,    1'b1, STATUS_OK,  15'd0},
		'{OP_ALLOC,   16'd8,     15'd0,     1'b0, 1'b0,       15'd0},
		'{OP_ALLOC,   16'd100,   15'd0,     1'b0, 1'b0,       15'd0},
		'{OP_RELEASE, 16'd0,     15'd16,    1'b0, 1'b0,       15'd0},
		'{OP_ALLOC,   16'd9,     15'd0,     1'b0, 1'b0,       15'd0},
		'{OP_INIT,    16'd0,     15'd0,     1'b1, STATUS_OK,  15'd0},
		'{OP_ALLOC,   16'd32736, 15'd0,     1'b1, STATUS_OK,  15'd16},
		'{OP_ALLOC,   16'd8,     15'd0,     1'b1, STATUS_OOM, 15'd0},
		'{OP_RELEASE, 16'd0,     15'd16,    1'b1, STATUS_OK,  15'd0},
		'{OP_ALLOC,   16'd32752, 15'd0,     1'b1, STATUS_OK,  15'd16},
		'{OP_RELEASE, 16'd0,     15'd16,    1'b1, STATUS_OK,  15'd0},
		'{OP_ALLOC,   16'd32753, 15'd0,     1'b1, STATUS_OOM, 15'd0}
	};

	int unsigned heap_settings [] = '{32768, 32, 39, 1000, 4096, 0, 32768};

	initial begin
		heap_cmd_t c;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			send_cmd(directed[i]);
			if (directed[i].op == OP_INIT) live_blocks.delete();
		end
		live_blocks.delete();
		freed_blocks.delete();
		foreach (heap_settings[p]) begin
			drain();
			write_heap_bytes(heap_settings[p] != 0 ? heap_settings[p]
				: 8 * $urandom_range(4, 4096));
			c = '{OP_INIT, 16'd0, 15'd0, 1'b0, 1'b0, 15'd0};
			send_cmd(c);
			for (int n = 0; n < 160; n++) begin
				random_cmd(c);
				send_cmd(c);
				if (p == 0 && n == 80) drain();
				else if (n % 20 >= 10) sender_gap();
			end
		end
		drain();
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	initial begin
		#500ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
